// ===== sv/fbc_pkg.sv =====
// ============================================================================
// fbc_pkg
// Shared types and constants of the four-bit teaching processor: word width,
// command, opcode and event codes, controller states and the result record.
// ============================================================================
package fbc_pkg;

    localparam int WORD_BITS  = 4;
    localparam int MEM_DEPTH  = 1 << WORD_BITS;
    localparam int CMD_BITS   = 2;
    localparam int EVENT_BITS = 2;

    typedef logic [WORD_BITS-1:0] word_t;

    // Request commands (code 3 is unused and ignored)
    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Instruction set; opcodes with the top bit set carry an operand nibble
    typedef enum logic [WORD_BITS-1:0] {
        OP_HALT  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_INC0  = 4'd3,
        OP_INC1  = 4'd4,
        OP_DEC0  = 4'd5,
        OP_DEC1  = 4'd6,
        OP_BELL  = 4'd7,
        OP_PRINT = 4'd8,
        OP_LDI0  = 4'd9,
        OP_LDI1  = 4'd10,
        OP_ST0   = 4'd11,
        OP_ST1   = 4'd12,
        OP_JMP   = 4'd13,
        OP_JZ    = 4'd14,
        OP_JNZ   = 4'd15
    } op_t;

    typedef enum logic [EVENT_BITS-1:0] {
        EV_NONE  = 2'd0,
        EV_BELL  = 2'd1,
        EV_PRINT = 2'd2
    } event_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH_ARG,
        S_EXEC,
        S_APPLY
    } state_t;

    // Result record as it waits in the output register
    typedef struct packed {
        event_t event_kind;
        word_t  printed_value;
        logic   halted;
        word_t  reg_zero;
        word_t  reg_one;
        word_t  next_address;
    } res_t;

endpackage

// ===== sv/fbc_if.sv =====
// ============================================================================
// fbc_if
// Valid/ready channels of the teaching processor: the command request
// channel and the result request channel.
// ============================================================================
interface fbc_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [fbc_pkg::CMD_BITS-1:0]  command;
    logic [fbc_pkg::WORD_BITS-1:0] load_address;
    logic [fbc_pkg::WORD_BITS-1:0] load_value;

    modport source (output valid, command, load_address, load_value, input ready);
    modport sink   (input valid, command, load_address, load_value, output ready);
endinterface

interface fbc_res_if;
    logic                           valid;
    logic                           ready;
    logic [fbc_pkg::EVENT_BITS-1:0] event_kind;
    logic [fbc_pkg::WORD_BITS-1:0]  printed_value;
    logic                           halted;
    logic [fbc_pkg::WORD_BITS-1:0]  reg_zero;
    logic [fbc_pkg::WORD_BITS-1:0]  reg_one;
    logic [fbc_pkg::WORD_BITS-1:0]  next_address;

    modport source (output valid, event_kind, printed_value, halted, reg_zero,
                    reg_one, next_address, input ready);
    modport sink   (input valid, event_kind, printed_value, halted, reg_zero,
                    reg_one, next_address, output ready);
endinterface

// ===== sv/four_bit_teaching_cpu.sv =====
// ============================================================================
// four_bit_teaching_cpu
// Four-bit teaching processor: sixteen nibbles of program memory, R0, R1 and
// an instruction pointer. Requests load memory, step one instruction or clear.
//
//  Channel | Dir | Handshake    | Payload
//  --------+-----+--------------+----------------------------------------------
//  cmd     | in  | valid/ready  | command, load_address, load_value
//  res     | out | valid/ready  | event_kind, printed_value, halted, reg_zero,
//          |     |              | reg_one, next_address
//
// A step request reads the opcode from the program RAM, then reads the operand,
// then executes and writes back; the single RAM read port puts the reads in
// turn. Load, clear and ignored requests go through the apply state. Program
// memory is held in the RAM with one valid flip-flop per entry; reset and
// clear drop all valid bits together, so no clearing pass is needed. A new
// request is taken while a result still waits in the output register; the
// last cycle of a request waits while that register is full and not being drained.
// ============================================================================
module four_bit_teaching_cpu (
    input  logic     clk,
    input  logic     rst_n,
    fbc_cmd_if.sink  cmd,
    fbc_res_if.source res
);

    localparam int WB = fbc_pkg::WORD_BITS;
    localparam int MD = fbc_pkg::MEM_DEPTH;

    // Controller and architectural state
    fbc_pkg::state_t              state_reg, state_next;
    logic [fbc_pkg::CMD_BITS-1:0] cmd_reg;
    fbc_pkg::word_t               addr_reg;
    fbc_pkg::word_t               value_reg;
    fbc_pkg::word_t               r0_reg, r0_next;
    fbc_pkg::word_t               r1_reg, r1_next;
    fbc_pkg::word_t               ip_reg, ip_next;
    logic                         stopped_reg, stopped_next;
    logic [MD-1:0]                valid_reg, valid_next;
    fbc_pkg::op_t                 op_reg;
    logic                         rd_vld_reg;
    fbc_pkg::res_t                res_reg, res_next;
    logic                         out_valid_reg, out_valid_next;

    // RAM ports
    logic           ram_wr_en;
    fbc_pkg::word_t ram_wr_addr;
    fbc_pkg::word_t ram_wr_data;
    logic           ram_rd_en;
    fbc_pkg::word_t ram_rd_addr;
    fbc_pkg::word_t ram_rd_data;
    fbc_pkg::word_t mem_word;

    logic accept;
    logic post_ok;
    logic op_long;
    logic rd_vld_snap;

    fbc_ram #(
        .WIDTH (WB),
        .DEPTH (MD)
    ) u_prog_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Handshake terms
    assign accept    = cmd.valid && cmd.ready;
    assign post_ok   = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == fbc_pkg::S_IDLE);

    // Entries never written since reset or clear read as zero
    assign mem_word    = rd_vld_reg ? ram_rd_data : '0;
    assign rd_vld_snap = valid_reg[ram_rd_addr];
    assign op_long     = op_reg[WB-1];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fbc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.command == fbc_pkg::CMD_STEP && !stopped_reg)
                        state_next = fbc_pkg::S_FETCH_ARG;
                    else
                        state_next = fbc_pkg::S_APPLY;
                end
            end
            fbc_pkg::S_FETCH_ARG:
            begin
                state_next = fbc_pkg::S_EXEC;
            end
            fbc_pkg::S_EXEC,
            fbc_pkg::S_APPLY:
            begin
                if (post_ok)
                    state_next = fbc_pkg::S_IDLE;
            end
        endcase
    end

    // RAM reads: opcode on accept, operand in the following cycle
    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = ip_reg;
        unique case (state_reg)
            fbc_pkg::S_IDLE:
            begin
                ram_rd_en   = accept;
                ram_rd_addr = ip_reg;
            end
            fbc_pkg::S_FETCH_ARG:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ip_reg + WB'(1);
            end
            fbc_pkg::S_EXEC,
            fbc_pkg::S_APPLY:
            begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    // Execute, apply and post the result
    always_comb
    begin
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        ip_next        = ip_reg;
        stopped_next   = stopped_reg;
        valid_next     = valid_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !res.ready;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = addr_reg;
        ram_wr_data    = value_reg;

        res_next.event_kind    = fbc_pkg::EV_NONE;
        res_next.printed_value = '0;

        if (state_reg == fbc_pkg::S_EXEC && post_ok)
        begin
            ip_next = ip_reg + (op_long ? WB'(2) : WB'(1));
            unique case (op_reg)
                fbc_pkg::OP_HALT:  stopped_next = 1'b1;
                fbc_pkg::OP_ADD:   r0_next = r0_reg + r1_reg;
                fbc_pkg::OP_SUB:   r0_next = r0_reg - r1_reg;
                fbc_pkg::OP_INC0:  r0_next = r0_reg + WB'(1);
                fbc_pkg::OP_INC1:  r1_next = r1_reg + WB'(1);
                fbc_pkg::OP_DEC0:  r0_next = r0_reg - WB'(1);
                fbc_pkg::OP_DEC1:  r1_next = r1_reg - WB'(1);
                fbc_pkg::OP_BELL:  res_next.event_kind = fbc_pkg::EV_BELL;
                fbc_pkg::OP_PRINT:
                begin
                    res_next.event_kind    = fbc_pkg::EV_PRINT;
                    res_next.printed_value = mem_word;
                end
                fbc_pkg::OP_LDI0:  r0_next = mem_word;
                fbc_pkg::OP_LDI1:  r1_next = mem_word;
                fbc_pkg::OP_ST0,
                fbc_pkg::OP_ST1:
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = mem_word;
                    ram_wr_data = (op_reg == fbc_pkg::OP_ST0) ? r0_reg : r1_reg;
                    valid_next[mem_word] = 1'b1;
                end
                fbc_pkg::OP_JMP:   ip_next = mem_word;
                fbc_pkg::OP_JZ:
                begin
                    if (r0_reg == '0)
                        ip_next = mem_word;
                end
                fbc_pkg::OP_JNZ:
                begin
                    if (r0_reg != '0)
                        ip_next = mem_word;
                end
            endcase
            out_valid_next = 1'b1;
        end
        else if (state_reg == fbc_pkg::S_APPLY && post_ok)
        begin
            unique case (cmd_reg)
                fbc_pkg::CMD_LOAD:
                begin
                    ram_wr_en             = 1'b1;
                    valid_next[addr_reg]  = 1'b1;
                end
                fbc_pkg::CMD_CLEAR:
                begin
                    valid_next   = '0;
                    r0_next      = '0;
                    r1_next      = '0;
                    ip_next      = '0;
                    stopped_next = 1'b0;
                end
                default:
                begin
                    // step while halted and the unused code change nothing
                end
            endcase
            out_valid_next = 1'b1;
        end
        else
        begin
            res_next.event_kind    = res_reg.event_kind;
            res_next.printed_value = res_reg.printed_value;
        end

        res_next.halted       = stopped_next;
        res_next.reg_zero     = r0_next;
        res_next.reg_one      = r1_next;
        res_next.next_address = ip_next;
        if (!out_valid_next || (out_valid_reg && !res.ready))
        begin
            // hold the waiting result untouched
            res_next = (out_valid_reg && !res.ready) ? res_reg : res_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbc_pkg::S_IDLE;
            r0_reg        <= '0;
            r1_reg        <= '0;
            ip_reg        <= '0;
            stopped_reg   <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r0_reg        <= r0_next;
            r1_reg        <= r1_next;
            ip_reg        <= ip_next;
            stopped_reg   <= stopped_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd.command;
            addr_reg  <= cmd.load_address;
            value_reg <= cmd.load_value;
        end
        if (ram_rd_en)
        begin
            rd_vld_reg <= rd_vld_snap;
        end
        if (state_reg == fbc_pkg::S_FETCH_ARG)
        begin
            op_reg <= fbc_pkg::op_t'(mem_word);
        end
        res_reg <= res_next;
    end

    // Drive the result channel
    assign res.valid         = out_valid_reg;
    assign res.event_kind    = res_reg.event_kind;
    assign res.printed_value = res_reg.printed_value;
    assign res.halted        = res_reg.halted;
    assign res.reg_zero      = res_reg.reg_zero;
    assign res.reg_one       = res_reg.reg_one;
    assign res.next_address  = res_reg.next_address;

    // Checks
    a_step_fetches: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == fbc_pkg::CMD_STEP && !stopped_reg
        |=> state_reg == fbc_pkg::S_FETCH_ARG)
        else $error("step request did not start the operand fetch");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg && !(state_reg == fbc_pkg::S_APPLY && cmd_reg == fbc_pkg::CMD_CLEAR)
        |=> stopped_reg)
        else $error("halt flag dropped without a clear");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == fbc_pkg::S_EXEC || state_reg == fbc_pkg::S_APPLY))
        else $error("program RAM written outside execute or apply");

    a_post_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid)
        |-> $past(state_reg == fbc_pkg::S_EXEC || state_reg == fbc_pkg::S_APPLY))
        else $error("result posted from a wrong state");

endmodule

// ===== sv/fbc_ram.sv =====
// ============================================================================
// fbc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
module fbc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== verif/tb_four_bit_teaching_cpu.sv =====
// ============================================================================
// tb_four_bit_teaching_cpu
// Self-checking bench for the four-bit teaching processor. A directed program
// covers halt, stepping while halted, loads while halted, the unused command,
// operand fetch from the last cell and pointer wrap. Random programs with
// random content then run, mixed with stray requests. A behavioral copy of the
// processor predicts each result, and the monitor checks every field in order.
// Both channels idle at random, except for one long steady stretch.
// ============================================================================
module tb_four_bit_teaching_cpu;

    localparam logic [fbc_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_REQS  = 1350;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_PCT     = 30;
    localparam int STEADY_FIRST = 400;
    localparam int STEADY_LAST  = 700;

    typedef struct packed {
        logic [fbc_pkg::CMD_BITS-1:0] command;
        fbc_pkg::word_t               load_address;
        fbc_pkg::word_t               load_value;
    } cpu_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fbc_cmd_if cmd_ch ();
    fbc_res_if res_ch ();

    four_bit_teaching_cpu i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always #5 clk = ~clk;

    // Request and result queues
    cpu_req_t      pending_reqs[$];
    fbc_pkg::res_t expected_results[$];

    // Processor state as the predictor sees it
    fbc_pkg::word_t prog_mem [fbc_pkg::MEM_DEPTH];
    fbc_pkg::word_t cpu_r0;
    fbc_pkg::word_t cpu_r1;
    fbc_pkg::word_t cpu_ip;
    logic           cpu_halted;

    int failures      = 0;
    int reqs_sent     = 0;
    int results_seen  = 0;
    int cycle_count   = 0;
    int steps_sent    = 0;
    int loads_sent    = 0;
    int clears_sent   = 0;
    int unused_sent   = 0;
    int bells_seen    = 0;
    int prints_seen   = 0;
    int halted_seen   = 0;

    function automatic void clear_cpu_state();
        foreach (prog_mem[i])
            prog_mem[i] = '0;
        cpu_r0     = '0;
        cpu_r1     = '0;
        cpu_ip     = '0;
        cpu_halted = 1'b0;
    endfunction

    // Apply one request to the predicted state and build its result
    function automatic fbc_pkg::res_t apply_request(logic [fbc_pkg::CMD_BITS-1:0] command,
                                                    fbc_pkg::word_t addr,
                                                    fbc_pkg::word_t value);
        fbc_pkg::res_t  r;
        fbc_pkg::op_t   op;
        fbc_pkg::word_t arg_addr;
        fbc_pkg::word_t arg;

        r = '0;
        case (command)
            fbc_pkg::CMD_LOAD: prog_mem[addr] = value;
            fbc_pkg::CMD_CLEAR: clear_cpu_state();
            fbc_pkg::CMD_STEP:
            begin
                if (!cpu_halted)
                begin
                    op       = fbc_pkg::op_t'(prog_mem[cpu_ip]);
                    arg_addr = cpu_ip + 4'd1;
                    arg      = prog_mem[arg_addr];
                    // Long opcodes skip their operand cell
                    cpu_ip = op[fbc_pkg::WORD_BITS-1] ? cpu_ip + 4'd2 : cpu_ip + 4'd1;
                    case (op)
                        fbc_pkg::OP_HALT:  cpu_halted = 1'b1;
                        fbc_pkg::OP_ADD:   cpu_r0 = cpu_r0 + cpu_r1;
                        fbc_pkg::OP_SUB:   cpu_r0 = cpu_r0 - cpu_r1;
                        fbc_pkg::OP_INC0:  cpu_r0 = cpu_r0 + 4'd1;
                        fbc_pkg::OP_INC1:  cpu_r1 = cpu_r1 + 4'd1;
                        fbc_pkg::OP_DEC0:  cpu_r0 = cpu_r0 - 4'd1;
                        fbc_pkg::OP_DEC1:  cpu_r1 = cpu_r1 - 4'd1;
                        fbc_pkg::OP_BELL:  r.event_kind = fbc_pkg::EV_BELL;
                        fbc_pkg::OP_PRINT:
                        begin
                            r.event_kind    = fbc_pkg::EV_PRINT;
                            r.printed_value = arg;
                        end
                        fbc_pkg::OP_LDI0:  cpu_r0 = arg;
                        fbc_pkg::OP_LDI1:  cpu_r1 = arg;
                        fbc_pkg::OP_ST0:   prog_mem[arg] = cpu_r0;
                        fbc_pkg::OP_ST1:   prog_mem[arg] = cpu_r1;
                        fbc_pkg::OP_JMP:   cpu_ip = arg;
                        fbc_pkg::OP_JZ:    if (cpu_r0 == '0) cpu_ip = arg;
                        default:           if (cpu_r0 != '0) cpu_ip = arg;
                    endcase
                end
            end
            default: ;
        endcase
        r.halted       = cpu_halted;
        r.reg_zero     = cpu_r0;
        r.reg_one      = cpu_r1;
        r.next_address = cpu_ip;
        return r;
    endfunction

    function automatic void queue_request(logic [fbc_pkg::CMD_BITS-1:0] command,
                                          fbc_pkg::word_t addr,
                                          fbc_pkg::word_t value);
        cpu_req_t q;

        q.command      = command;
        q.load_address = addr;
        q.load_value   = value;
        pending_reqs.push_back(q);
    endfunction

    function automatic fbc_pkg::word_t rand_word();
        return fbc_pkg::word_t'($urandom_range(0, fbc_pkg::MEM_DEPTH - 1));
    endfunction

    function automatic void check_field(string name, logic [fbc_pkg::WORD_BITS-1:0] want,
                                        logic [fbc_pkg::WORD_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Drive requests from the pending queue and predict each one on acceptance
    always @(posedge clk or negedge rst_n)
    begin : drive_cmd
        cpu_req_t nxt;
        logic     steady;

        if (!rst_n)
        begin
            cmd_ch.valid        <= 1'b0;
            cmd_ch.command      <= fbc_pkg::CMD_LOAD;
            cmd_ch.load_address <= '0;
            cmd_ch.load_value   <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                expected_results.push_back(apply_request(cmd_ch.command,
                                                         cmd_ch.load_address,
                                                         cmd_ch.load_value));
                reqs_sent++;
                case (cmd_ch.command)
                    fbc_pkg::CMD_LOAD:  loads_sent++;
                    fbc_pkg::CMD_STEP:  steps_sent++;
                    fbc_pkg::CMD_CLEAR: clears_sent++;
                    default:            unused_sent++;
                endcase
            end
            steady = (reqs_sent >= STEADY_FIRST) && (reqs_sent < STEADY_LAST);
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (pending_reqs.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = pending_reqs.pop_front();
                    cmd_ch.valid        <= 1'b1;
                    cmd_ch.command      <= nxt.command;
                    cmd_ch.load_address <= nxt.load_address;
                    cmd_ch.load_value   <= nxt.load_value;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Check each result against the oldest prediction; stall at random
    always @(posedge clk or negedge rst_n)
    begin : watch_res
        fbc_pkg::res_t want;
        logic          steady;

        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("event_kind", fbc_pkg::word_t'(want.event_kind),
                                fbc_pkg::word_t'(res_ch.event_kind));
                    check_field("printed_value", want.printed_value, res_ch.printed_value);
                    check_field("halted", fbc_pkg::word_t'(want.halted),
                                fbc_pkg::word_t'(res_ch.halted));
                    check_field("reg_zero", want.reg_zero, res_ch.reg_zero);
                    check_field("reg_one", want.reg_one, res_ch.reg_one);
                    check_field("next_address", want.next_address, res_ch.next_address);
                    if (want.event_kind == fbc_pkg::EV_BELL)
                        bells_seen++;
                    if (want.event_kind == fbc_pkg::EV_PRINT)
                        prints_seen++;
                    if (want.halted)
                        halted_seen++;
                end
            end
            steady = (results_seen >= STEADY_FIRST) && (results_seen < STEADY_LAST);
            res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Build the stimulus, run it and report
    initial
    begin : run_test
        int useful;
        int n_loads;
        int n_steps;
        logic [fbc_pkg::CMD_BITS-1:0] c;

        clear_cpu_state();

        // Directed: halt from empty memory, then stepping and loading while halted
        queue_request(fbc_pkg::CMD_STEP, 4'd0, 4'd0);
        queue_request(fbc_pkg::CMD_STEP, 4'd15, 4'd15);
        queue_request(fbc_pkg::CMD_LOAD, 4'd15, 4'd15);
        queue_request(CMD_UNUSED, 4'd15, 4'd15);
        queue_request(fbc_pkg::CMD_STEP, 4'd0, 4'd0);
        queue_request(fbc_pkg::CMD_CLEAR, 4'd15, 4'd15);
        // Jump to the last cell, print with the operand wrapping to cell 0,
        // skip a jump on zero R0, wrap R0 down to 15, jump back on nonzero
        queue_request(fbc_pkg::CMD_LOAD, 4'd0, fbc_pkg::OP_JMP);
        queue_request(fbc_pkg::CMD_LOAD, 4'd1, fbc_pkg::OP_JNZ);
        queue_request(fbc_pkg::CMD_LOAD, 4'd15, fbc_pkg::OP_PRINT);
        queue_request(fbc_pkg::CMD_LOAD, 4'd3, fbc_pkg::OP_DEC0);
        queue_request(fbc_pkg::CMD_LOAD, 4'd4, fbc_pkg::OP_JNZ);
        queue_request(fbc_pkg::CMD_LOAD, 4'd5, 4'd0);
        repeat (7)
            queue_request(fbc_pkg::CMD_STEP, 4'd0, 4'd0);

        // Random: mostly whole programs that then run, some stray requests
        useful = 0;
        while (useful < RANDOM_REQS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    queue_request(fbc_pkg::CMD_CLEAR, rand_word(), rand_word());
                    useful++;
                end
                n_loads = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6)
                                                      : fbc_pkg::MEM_DEPTH;
                for (int i = 0; i < n_loads; i++)
                begin
                    if (n_loads == fbc_pkg::MEM_DEPTH)
                        queue_request(fbc_pkg::CMD_LOAD, fbc_pkg::word_t'(i), rand_word());
                    else
                        queue_request(fbc_pkg::CMD_LOAD, rand_word(), rand_word());
                    useful++;
                end
                n_steps = $urandom_range(4, 30);
                repeat (n_steps)
                    queue_request(fbc_pkg::CMD_STEP, rand_word(), rand_word());
                useful += n_steps;
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    c = fbc_pkg::CMD_BITS'($urandom_range(0, 3));
                    queue_request(c, rand_word(), rand_word());
                    if (c != CMD_UNUSED)
                        useful++;
                end
            end
        end

        // Hold reset once at the start, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to go out and every result to come back
        while (pending_reqs.size() != 0 || cmd_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d steps, %0d loads, %0d clears, %0d unused codes.",
                 reqs_sent, steps_sent, loads_sent, clears_sent, unused_sent);
        $display("Checked %0d results: %0d bells, %0d prints, %0d while halted.",
                 results_seen, bells_seen, prints_seen, halted_seen);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
